@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Each macro names its check and reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

@@ src/imdu_pkg.sv @@
// Package for the integer multiply/divide unit: opcodes, widths, stage data.
// Used by imdu_pipe and the top level; depends on nothing.
package imdu_pkg;
   localparam int DATA_BITS = 32;
   // Iterations of the shift-add or divide loop resolved in one stage.
   localparam int STEPS_PER_STAGE = 4;
   localparam int NUM_STAGES = DATA_BITS / STEPS_PER_STAGE;

   typedef enum logic [2:0] {
      OP_MULU = 3'd0,
      OP_MULS = 3'd1,
      OP_DIVU = 3'd2,
      OP_DIVS = 3'd3,
      OP_ADD  = 3'd4,
      OP_SUB  = 3'd5
   } opcode_type;

   // Working set of one beat as it moves down the pipe.
   typedef struct packed {
      logic [2:0]           op;
      logic                 neg_rem;
      logic                 neg_quo;
      logic [DATA_BITS-1:0] a;     // multiplicand or divisor magnitude
      logic [DATA_BITS-1:0] b;     // original multiplier, for the sign fix
      logic [DATA_BITS-1:0] hi;    // partial product high or remainder
      logic [DATA_BITS-1:0] lo;    // multiplier shift or quotient shift
      logic                 is_mul;
      logic                 is_div;
   } stage_type;
endpackage

@@ src/imdu_pipe.sv @@
// Iteration pipeline of the unit: four shift-add or restoring-divide steps per
// stage, with a valid bit beside each stage. Depends on imdu_pkg.
module imdu_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  imdu_pkg::stage_type in_data,
   output logic                out_valid,
   output imdu_pkg::stage_type out_data
);
   imdu_pkg::stage_type stage_ff [imdu_pkg::NUM_STAGES];
   imdu_pkg::stage_type stage_in [imdu_pkg::NUM_STAGES];
   logic [imdu_pkg::NUM_STAGES-1:0] valid_ff;

   function automatic imdu_pkg::stage_type do_steps(input imdu_pkg::stage_type s);
      imdu_pkg::stage_type t;
      logic [imdu_pkg::DATA_BITS:0] sum;
      logic over;
      logic [imdu_pkg::DATA_BITS-1:0] r;
      t = s;
      for (int i = 0; i < imdu_pkg::STEPS_PER_STAGE; i++) begin
         if (t.is_mul) begin
            sum = t.lo[0] ? ({1'b0, t.hi} + {1'b0, t.a}) : {1'b0, t.hi};
            t.lo = {sum[0], t.lo[imdu_pkg::DATA_BITS-1:1]};
            t.hi = sum[imdu_pkg::DATA_BITS:1];
         end else if (t.is_div) begin
            over = t.hi[imdu_pkg::DATA_BITS-1];
            r = {t.hi[imdu_pkg::DATA_BITS-2:0], t.lo[imdu_pkg::DATA_BITS-1]};
            t.lo = {t.lo[imdu_pkg::DATA_BITS-2:0], 1'b0};
            if (over || (r >= t.a)) begin
               r = r - t.a;
               t.lo[0] = 1'b1;
            end
            t.hi = r;
         end
      end
      return t;
   endfunction

   always_comb begin
      stage_in[0] = do_steps(in_data);
      for (int k = 1; k < imdu_pkg::NUM_STAGES; k++) begin
         stage_in[k] = do_steps(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[imdu_pkg::NUM_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < imdu_pkg::NUM_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[imdu_pkg::NUM_STAGES-1];
   assign out_data  = stage_ff[imdu_pkg::NUM_STAGES-1];
endmodule

@@ src/integer_multiply_divide_unit.sv @@
// Top level of the integer multiply/divide unit: operand prep, pipe, fix-up.
// Depends on imdu_pkg and imdu_pipe.
//
//   channel   ports                                      role
//   request   req_valid req_stall req_opcode/operand_*   in
//   response  rsp_valid rsp_stall rsp_result_*           out
//
// A beat passes through eight loop stages of four iterations each, the last
// one feeding the sign fix-up into the output register, before it shows on
// the response port. One beat is accepted per cycle while req_stall is low.
// Reset empties the pipe. A response stall holds the whole pipe while the
// output is full; req_stall is high only then, so nothing is lost or repeated.
module integer_multiply_divide_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_high,
   output logic [31:0] rsp_result_low
);
   localparam int W = imdu_pkg::DATA_BITS;

   logic advance;
   imdu_pkg::stage_type prep;
   imdu_pkg::stage_type pipe_out;
   logic pipe_valid;
   logic sa, sb;
   logic [W-1:0] ma, mb;
   logic valid_ff;
   logic [31:0] high_ff, low_ff, high_in, low_in;

   assign advance   = !(valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      sa = req_operand_a[W-1];
      sb = req_operand_b[W-1];
      ma = sa ? (~req_operand_a + 1'b1) : req_operand_a;
      mb = sb ? (~req_operand_b + 1'b1) : req_operand_b;
      prep = '0;
      prep.op = req_opcode;
      prep.b  = req_operand_b;
      unique case (req_opcode)
         imdu_pkg::OP_MULU, imdu_pkg::OP_MULS: begin
            prep.is_mul = 1'b1;
            prep.a  = req_operand_a;
            prep.lo = req_operand_b;
         end
         imdu_pkg::OP_DIVU: begin
            prep.is_div = 1'b1;
            prep.a  = req_operand_b;
            prep.lo = req_operand_a;
         end
         imdu_pkg::OP_DIVS: begin
            prep.is_div  = 1'b1;
            prep.a       = mb;
            prep.lo      = ma;
            prep.neg_rem = sa;
            prep.neg_quo = sa ^ sb;
         end
         imdu_pkg::OP_ADD: prep.lo = req_operand_a + req_operand_b;
         imdu_pkg::OP_SUB: prep.lo = req_operand_a - req_operand_b;
         default: prep.lo = '0;
      endcase
   end

   imdu_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (prep),
      .out_valid (pipe_valid),
      .out_data  (pipe_out)
   );

   // Sign fix-up: signed-multiply high-word correction and signed divide negation.
   always_comb begin
      high_in = pipe_out.hi;
      low_in  = pipe_out.lo;
      if (pipe_out.op == imdu_pkg::OP_MULS) begin
         high_in = pipe_out.hi - (pipe_out.a[W-1] ? pipe_out.b : '0)
                               - (pipe_out.b[W-1] ? pipe_out.a : '0);
      end
      if (pipe_out.neg_rem) high_in = ~pipe_out.hi + 1'b1;
      if (pipe_out.neg_quo) low_in  = ~pipe_out.lo + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_high = high_ff;
   assign rsp_result_low  = low_ff;
endmodule

@@ src/imdu_checker.sv @@
// Port-level checker for the integer multiply/divide unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module imdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_high,
   input logic [31:0] rsp_result_low
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CHK_NEXT(a_rsp_data, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_result_high) && $stable(rsp_result_low))
   `CHK_IMPL(a_no_stall_idle, clock, reset, !rsp_valid, !req_stall)
   `CHK_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule

bind integer_multiply_divide_unit imdu_checker u_imdu_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_result_high(rsp_result_high),
   .rsp_result_low(rsp_result_low)
);
